### rtl/lcpc_pkg.sv
// ----------------------------------------------------------------------------
// lcpc_pkg
// Shared types and constants for the line CLUT pixel converter.
// ----------------------------------------------------------------------------
package lcpc_pkg;

  localparam int unsigned CompW     = 8;
  localparam int unsigned ChanW     = 5;
  localparam int unsigned BgW       = 3 * ChanW;
  localparam int unsigned PixW      = BgW + 1;
  localparam int unsigned CfgW      = 11;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CountW    = 10;
  localparam int unsigned MaxLength = 1024;

  localparam logic [CfgIdxW-1:0] CFG_PIXELS_PER_LINE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LINES_PER_FRAME = 1'b1;

  localparam logic [CfgW-1:0] PIXELS_PER_LINE_RST = 11'd320;
  localparam logic [CfgW-1:0] LINES_PER_FRAME_RST = 11'd240;

  typedef enum logic [1:0] {
    OP_TABLE_WRITE = 2'd0,
    OP_LINE_HEADER = 2'd1,
    OP_PIXEL       = 2'd2
  } op_e;

  typedef struct packed {
    logic eol;
    logic eof;
  } line_flags_t;

  function automatic logic [CompW-1:0] expand5(input logic [ChanW-1:0] v);
    return {v, v[ChanW-1:ChanW-3]};
  endfunction

endpackage

### rtl/lcpc_clut.sv
// ----------------------------------------------------------------------------
// lcpc_clut
// Red, green and blue color tables: one entry write and one lookup per table.
// ----------------------------------------------------------------------------
module lcpc_clut #(
  parameter int unsigned TABLE_ENTRIES = 32,
  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [IdxW-1:0]            wr_idx_i,
  input  logic [lcpc_pkg::CompW-1:0] wr_red_i,
  input  logic [lcpc_pkg::CompW-1:0] wr_green_i,
  input  logic [lcpc_pkg::CompW-1:0] wr_blue_i,
  input  logic [IdxW-1:0]            rd_red_idx_i,
  input  logic [IdxW-1:0]            rd_green_idx_i,
  input  logic [IdxW-1:0]            rd_blue_idx_i,
  output logic [lcpc_pkg::CompW-1:0] rd_red_o,
  output logic [lcpc_pkg::CompW-1:0] rd_green_o,
  output logic [lcpc_pkg::CompW-1:0] rd_blue_o
);
  import lcpc_pkg::*;

  logic [CompW-1:0] red_q   [TABLE_ENTRIES];
  logic [CompW-1:0] green_q [TABLE_ENTRIES];
  logic [CompW-1:0] blue_q  [TABLE_ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        red_q[i]   <= '0;
        green_q[i] <= '0;
        blue_q[i]  <= '0;
      end
    end else if (wr_en_i) begin
      red_q[wr_idx_i]   <= wr_red_i;
      green_q[wr_idx_i] <= wr_green_i;
      blue_q[wr_idx_i]  <= wr_blue_i;
    end
  end

  assign rd_red_o   = red_q[rd_red_idx_i];
  assign rd_green_o = green_q[rd_green_idx_i];
  assign rd_blue_o  = blue_q[rd_blue_idx_i];

endmodule

### rtl/lcpc_counter.sv
// ----------------------------------------------------------------------------
// lcpc_counter
// Line geometry registers and column/row counters for end-of-line and frame.
// ----------------------------------------------------------------------------
module lcpc_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lcpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lcpc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         step_i,
  output lcpc_pkg::line_flags_t        flags_o
);
  import lcpc_pkg::*;

  logic [CfgW-1:0]   ppl_q, lpf_q;
  logic [CountW-1:0] col_q, col_d, row_q, row_d;
  logic [CountW-1:0] col_last, row_last;

  function automatic logic [CountW-1:0] last_pos(input logic [CfgW-1:0] len);
    logic [CfgW-1:0] lm1;
    lm1 = len - 1'b1;
    if (len == '0) begin
      return '0;
    end else if (len > CfgW'(MaxLength)) begin
      return CountW'(MaxLength - 1);
    end
    return lm1[CountW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppl_q <= PIXELS_PER_LINE_RST;
      lpf_q <= LINES_PER_FRAME_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PIXELS_PER_LINE: ppl_q <= cfg_data_i;
        CFG_LINES_PER_FRAME: lpf_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign col_last    = last_pos(ppl_q);
  assign row_last    = last_pos(lpf_q);
  assign flags_o.eol = (col_q >= col_last);
  assign flags_o.eof = flags_o.eol && (row_q >= row_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (flags_o.eol) begin
        col_d = '0;
        row_d = flags_o.eof ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### rtl/line_clut_pixel_converter.sv
// ----------------------------------------------------------------------------
// line_clut_pixel_converter
// RGB 5:5:5 pixel to 8-bit component conversion through color tables, a per-line background or fixed expansion.
// ----------------------------------------------------------------------------
// One item is taken per clock while the input is not stalled. An accepted item
// sits in the input register, where table writes, line headers and the
// column/row counters take effect and a pixel's color is looked up; the pixel
// result is written to the output register as the pixel leaves the input
// register, and leaves the block from there. The output register holds a
// result while the sink stalls, and the input stalls only when a pixel in the
// input register finds the output register still held by a stalling sink.
module line_clut_pixel_converter #(
  parameter int unsigned TABLE_ENTRIES = 32,
  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lcpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lcpc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [IdxW-1:0]              entry_index_i,
  input  logic [lcpc_pkg::CompW-1:0]   red_entry_i,
  input  logic [lcpc_pkg::CompW-1:0]   green_entry_i,
  input  logic [lcpc_pkg::CompW-1:0]   blue_entry_i,
  input  logic [lcpc_pkg::BgW-1:0]     background_color_i,
  input  logic                         fixed_table_enable_i,
  input  logic [lcpc_pkg::PixW-1:0]    pixel_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lcpc_pkg::CompW-1:0]   blue_out_o,
  output logic [lcpc_pkg::CompW-1:0]   green_out_o,
  output logic [lcpc_pkg::CompW-1:0]   red_out_o,
  output logic                         end_of_line_o,
  output logic                         end_of_frame_o
);
  import lcpc_pkg::*;

  logic             s0_valid_q;
  logic [1:0]       op_q;
  logic [IdxW-1:0]  entry_q;
  logic [CompW-1:0] red_e_q, green_e_q, blue_e_q;
  logic [BgW-1:0]   bg_in_q;
  logic             fix_in_q;
  logic [PixW-1:0]  pix_q;

  logic [BgW-1:0]   line_bg_q;
  logic             fix_en_q;

  logic             out_valid_q;
  logic [CompW-1:0] blue_q, green_q, red_q;
  logic             eol_q, eof_q;

  logic             in_xfer, out_free, is_pixel, s0_fire, pix_fire;
  logic             tbl_we, hdr_we;
  logic [ChanW-1:0] b5, g5, r5;
  logic [CompW-1:0] tbl_red, tbl_green, tbl_blue;
  logic [CompW-1:0] blue_d, green_d, red_d;
  line_flags_t      flags;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_pixel   = (op_q == OP_PIXEL);
  assign s0_fire    = s0_valid_q && (!is_pixel || out_free);
  assign pix_fire   = s0_fire && is_pixel;
  assign tbl_we     = s0_fire && (op_q == OP_TABLE_WRITE);
  assign hdr_we     = s0_fire && (op_q == OP_LINE_HEADER);
  assign in_stall_o = s0_valid_q && !s0_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s0_valid_q <= 1'b1;
    end else if (s0_fire) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= op_i;
      entry_q   <= entry_index_i;
      red_e_q   <= red_entry_i;
      green_e_q <= green_entry_i;
      blue_e_q  <= blue_entry_i;
      bg_in_q   <= background_color_i;
      fix_in_q  <= fixed_table_enable_i;
      pix_q     <= pixel_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bg_q <= '0;
      fix_en_q  <= 1'b0;
    end else if (hdr_we) begin
      line_bg_q <= bg_in_q;
      fix_en_q  <= fix_in_q;
    end
  end

  assign b5 = pix_q[ChanW-1:0];
  assign g5 = pix_q[2*ChanW-1:ChanW];
  assign r5 = pix_q[3*ChanW-1:2*ChanW];

  lcpc_clut #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_clut (
    .clk_i,
    .rst_ni,
    .wr_en_i       (tbl_we),
    .wr_idx_i      (entry_q),
    .wr_red_i      (red_e_q),
    .wr_green_i    (green_e_q),
    .wr_blue_i     (blue_e_q),
    .rd_red_idx_i  (r5[IdxW-1:0]),
    .rd_green_idx_i(g5[IdxW-1:0]),
    .rd_blue_idx_i (b5[IdxW-1:0]),
    .rd_red_o      (tbl_red),
    .rd_green_o    (tbl_green),
    .rd_blue_o     (tbl_blue)
  );

  lcpc_counter u_counter (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .step_i (pix_fire),
    .flags_o(flags)
  );

  always_comb begin
    if (pix_q == '0) begin
      blue_d  = CompW'(line_bg_q[ChanW-1:0]);
      green_d = CompW'(line_bg_q[2*ChanW-1:ChanW]);
      red_d   = CompW'(line_bg_q[3*ChanW-1:2*ChanW]);
    end else if (fix_en_q && pix_q[PixW-1]) begin
      blue_d  = expand5(b5);
      green_d = expand5(g5);
      red_d   = expand5(r5);
    end else begin
      blue_d  = tbl_blue;
      green_d = tbl_green;
      red_d   = tbl_red;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      blue_q  <= blue_d;
      green_q <= green_d;
      red_q   <= red_d;
      eol_q   <= flags.eol;
      eof_q   <= flags.eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign blue_out_o     = blue_q;
  assign green_out_o    = green_q;
  assign red_out_o      = red_q;
  assign end_of_line_o  = eol_q;
  assign end_of_frame_o = eof_q;

  a_eof_has_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!end_of_frame_o || end_of_line_o))
    else $error("end of frame without end of line");

  a_pixel_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_fire |=> out_valid_o)
    else $error("pixel transfer lost its result");

  a_no_result_for_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && !is_pixel && !out_valid_o) |=> !out_valid_o)
    else $error("result produced by a non-pixel item");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s0_valid_q && is_pixel && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked pixel");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line CLUT pixel converter. Table writes, line
// headers and pixels are driven through the valid/stall input channel and a
// local color model predicts every pixel result, including the end-of-line and
// end-of-frame flags. Results are compared in order as they leave the output
// channel, under random sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import lcpc_pkg::*;

  localparam logic [1:0]  OpUndefined   = 2'd3;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned MaxPrinted    = 100;

  typedef struct packed {
    logic [CompW-1:0] blue;
    logic [CompW-1:0] green;
    logic [CompW-1:0] red;
    logic             eol;
    logic             eof;
  } pixel_result_t;

  logic               clk_i                = 1'b0;
  logic               rst_ni               = 1'b0;
  logic               cfg_we_i             = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i          = '0;
  logic [CfgW-1:0]    cfg_data_i           = '0;
  logic               in_valid_i           = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i                 = '0;
  logic [ChanW-1:0]   entry_index_i        = '0;
  logic [CompW-1:0]   red_entry_i          = '0;
  logic [CompW-1:0]   green_entry_i        = '0;
  logic [CompW-1:0]   blue_entry_i         = '0;
  logic [BgW-1:0]     background_color_i   = '0;
  logic               fixed_table_enable_i = 1'b0;
  logic [PixW-1:0]    pixel_word_i         = '0;
  logic               out_valid_o;
  logic               out_stall_i          = 1'b0;
  logic [CompW-1:0]   blue_out_o;
  logic [CompW-1:0]   green_out_o;
  logic [CompW-1:0]   red_out_o;
  logic               end_of_line_o;
  logic               end_of_frame_o;

  // color model
  logic [CompW-1:0] red_lut   [32];
  logic [CompW-1:0] green_lut [32];
  logic [CompW-1:0] blue_lut  [32];
  logic [BgW-1:0]   line_bg     = '0;
  logic             fixed_en    = 1'b0;
  int unsigned      col_count   = 0;
  int unsigned      row_count   = 0;
  logic [CfgW-1:0]  line_length = PIXELS_PER_LINE_RST;
  logic [CfgW-1:0]  frame_lines = LINES_PER_FRAME_RST;

  pixel_result_t expected_pixels[$];

  int unsigned mismatch_count   = 0;
  int unsigned sender_idle_pct  = 0;
  int unsigned stall_pct        = 0;
  bit          holdoff_request  = 1'b0;
  int unsigned holdoff_left     = 0;
  int unsigned quiet_cycles     = 0;

  line_clut_pixel_converter uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .op_i                 (op_i),
    .entry_index_i        (entry_index_i),
    .red_entry_i          (red_entry_i),
    .green_entry_i        (green_entry_i),
    .blue_entry_i         (blue_entry_i),
    .background_color_i   (background_color_i),
    .fixed_table_enable_i (fixed_table_enable_i),
    .pixel_word_i         (pixel_word_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .blue_out_o           (blue_out_o),
    .green_out_o          (green_out_o),
    .red_out_o            (red_out_o),
    .end_of_line_o        (end_of_line_o),
    .end_of_frame_o       (end_of_frame_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < 32; i++) begin
      red_lut[i]   = '0;
      green_lut[i] = '0;
      blue_lut[i]  = '0;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("ERROR %0t: %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  function automatic int unsigned clamp_length(input logic [CfgW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxLength) return MaxLength;
    return 32'(v);
  endfunction

  task automatic convert_transfer(input logic [1:0] op, input logic [ChanW-1:0] idx,
                                  input logic [CompW-1:0] r, input logic [CompW-1:0] g,
                                  input logic [CompW-1:0] b, input logic [BgW-1:0] bg,
                                  input logic fix, input logic [PixW-1:0] px);
    pixel_result_t res;
    int unsigned   col_last;
    int unsigned   row_last;
    case (op)
      OP_TABLE_WRITE: begin
        red_lut[idx]   = r;
        green_lut[idx] = g;
        blue_lut[idx]  = b;
      end
      OP_LINE_HEADER: begin
        line_bg  = bg;
        fixed_en = fix;
      end
      OP_PIXEL: begin
        res = '0;
        if (px == '0) begin
          res.blue  = {3'b000, line_bg[4:0]};
          res.green = {3'b000, line_bg[9:5]};
          res.red   = {3'b000, line_bg[14:10]};
        end else if (fixed_en && px[15]) begin
          res.blue  = {px[4:0], px[4:2]};
          res.green = {px[9:5], px[9:7]};
          res.red   = {px[14:10], px[14:12]};
        end else begin
          res.blue  = blue_lut[px[4:0]];
          res.green = green_lut[px[9:5]];
          res.red   = red_lut[px[14:10]];
        end
        col_last = clamp_length(line_length) - 1;
        row_last = clamp_length(frame_lines) - 1;
        // a counter at or past the last position wraps on this pixel
        if (col_count >= col_last) begin
          res.eol   = 1'b1;
          col_count = 0;
          if (row_count >= row_last) begin
            res.eof   = 1'b1;
            row_count = 0;
          end else begin
            row_count++;
          end
        end else begin
          col_count++;
        end
        expected_pixels.push_back(res);
      end
      default: ;
    endcase
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [1:0] op, input logic [ChanW-1:0] idx,
                           input logic [CompW-1:0] r, input logic [CompW-1:0] g,
                           input logic [CompW-1:0] b, input logic [BgW-1:0] bg,
                           input logic fix, input logic [PixW-1:0] px);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i           <= 1'b1;
    op_i                 <= op;
    entry_index_i        <= idx;
    red_entry_i          <= r;
    green_entry_i        <= g;
    blue_entry_i         <= b;
    background_color_i   <= bg;
    fixed_table_enable_i <= fix;
    pixel_word_i         <= px;
    do @(posedge clk_i); while (in_stall_o);
    convert_transfer(op, idx, r, g, b, bg, fix, px);
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input logic [PixW-1:0] px);
    send_item(OP_PIXEL, ChanW'($urandom), CompW'($urandom), CompW'($urandom),
              CompW'($urandom), BgW'($urandom), 1'($urandom), px);
  endtask

  task automatic send_table_write(input logic [ChanW-1:0] idx, input logic [CompW-1:0] r,
                                  input logic [CompW-1:0] g, input logic [CompW-1:0] b);
    send_item(OP_TABLE_WRITE, idx, r, g, b, BgW'($urandom), 1'($urandom),
              PixW'($urandom));
  endtask

  task automatic send_header(input logic [BgW-1:0] bg, input logic fix);
    send_item(OP_LINE_HEADER, ChanW'($urandom), CompW'($urandom), CompW'($urandom),
              CompW'($urandom), bg, fix, PixW'($urandom));
  endtask

  task automatic send_undefined();
    send_item(OpUndefined, ChanW'($urandom), CompW'($urandom), CompW'($urandom),
              CompW'($urandom), BgW'($urandom), 1'($urandom), PixW'($urandom));
  endtask

  function automatic logic [PixW-1:0] random_pixel();
    if ($urandom_range(0, 99) < 8) return '0;
    return PixW'($urandom);
  endfunction

  // drops valid and lets all pending work leave the block
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] index,
                                input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(negedge clk_i);
    if (index == CFG_PIXELS_PER_LINE) line_length = value;
    else frame_lines = value;
  endtask

  task automatic write_geometry(input logic [CfgW-1:0] ppl, input logic [CfgW-1:0] lpf);
    wait_quiet();
    write_register(CFG_PIXELS_PER_LINE, ppl);
    write_register(CFG_LINES_PER_FRAME, lpf);
    cfg_we_i <= 1'b0;
  endtask

  // lines of header, a few table writes and pixels, with some broken lines and noise
  task automatic run_lines(input logic [CfgW-1:0] ppl, input logic [CfgW-1:0] lpf,
                           input int unsigned idle_pct, input int unsigned stall_percent,
                           input int unsigned count);
    int unsigned sent;
    sent = 0;
    write_geometry(ppl, lpf);
    sender_idle_pct = idle_pct;
    stall_pct       = stall_percent;
    while (sent < count) begin
      if ($urandom_range(0, 9) != 0) begin
        send_header(BgW'($urandom), $urandom_range(0, 3) != 0);
        sent++;
      end
      repeat ($urandom_range(0, 3)) begin
        send_table_write(ChanW'($urandom), CompW'($urandom), CompW'($urandom),
                         CompW'($urandom));
        sent++;
      end
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 19) == 0) send_undefined();
        send_pixel(random_pixel());
        sent++;
      end
    end
  endtask

  task automatic test_directed_cases();
    write_geometry(11'd3, 11'd2);
    sender_idle_pct = 0;
    stall_pct       = 0;
    send_table_write(5'd0, 8'h00, 8'hFF, 8'h55);
    send_table_write(5'd31, 8'hFF, 8'h00, 8'hAA);
    send_header(15'h7FFF, 1'b1);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    send_pixel(16'h801F);
    send_pixel(16'h0001);
    send_header(15'h0000, 1'b0);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_undefined();
    send_pixel(16'h7C00);
    send_header(15'h2AAA, 1'b1);
    send_pixel(16'h0000);
    send_table_write(5'd16, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'h4210);
    send_pixel(16'hC210);
    send_header(15'h5555, 1'b0);
    send_pixel(16'h0000);
  endtask

  task automatic test_steady_stream();
    run_lines(11'd0, 11'd0, 0, 0, 260);
  endtask

  task automatic test_sender_gaps();
    run_lines(11'd1024, 11'd2047, 56, 0, 260);
  endtask

  task automatic test_receiver_stalls();
    // shorter lines than the column count reached so far
    run_lines(CfgW'($urandom_range(2, 12)), CfgW'($urandom_range(1, 4)), 0, 56, 260);
  endtask

  task automatic test_gaps_and_stalls();
    run_lines(CfgW'($urandom_range(1, 20)), CfgW'($urandom_range(1, 6)), 38, 38, 260);
  endtask

  task automatic test_output_holdoff();
    write_geometry(11'd2047, 11'd0);
    sender_idle_pct = 0;
    stall_pct       = 30;
    holdoff_request = 1'b1;
    repeat (80) send_pixel(random_pixel());
  endtask

  always @(negedge clk_i) begin : receiver
    if (holdoff_request) begin
      holdoff_left    = HoldOffCycles;
      holdoff_request = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    pixel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with no pixel pending", 32'(blue_out_o), 0);
      end else begin
        want = expected_pixels.pop_front();
        if (blue_out_o !== want.blue) begin
          report_mismatch("blue_out", 32'(blue_out_o), 32'(want.blue));
        end
        if (green_out_o !== want.green) begin
          report_mismatch("green_out", 32'(green_out_o), 32'(want.green));
        end
        if (red_out_o !== want.red) begin
          report_mismatch("red_out", 32'(red_out_o), 32'(want.red));
        end
        if (end_of_line_o !== want.eol) begin
          report_mismatch("end_of_line", 32'(end_of_line_o), 32'(want.eol));
        end
        if (end_of_frame_o !== want.eof) begin
          report_mismatch("end_of_frame", 32'(end_of_frame_o), 32'(want.eof));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_steady_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_gaps_and_stalls();
    test_output_holdoff();
    stall_pct = 0;
    wait_quiet();
    if (expected_pixels.size() != 0) begin
      report_mismatch("pixels never converted", expected_pixels.size(), 0);
    end
    if (mismatch_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
